// ===== src/sha256_byte_stream_hasher_macros.svh =====
// assertion macros for the sha-256 hasher checker
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// implication checked on every clock, off in reset
`define SHA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== src/shabs_pkg.sv =====
// shared types and constants for the sha-256 hasher
package shabs_pkg;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW = 2;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_beat_t;

	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} out_beat_t;

	// work for the back end: one byte, or a final padding pass
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_byte;
		logic       is_final;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_EMIT
	} bk_state_t;

	localparam word_t RoundK [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	localparam word_t InitHash [8] = '{
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ===== src/shabs_if.sv =====
// valid/ready channel interfaces
interface shabs_in_if import shabs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_beat_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface shabs_out_if import shabs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_beat_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/shabs_front.sv =====
// front end: filters input beats and queues work for the back end
module shabs_front import shabs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	shabs_in_if.sink         in_ch,
	output cmd_t             cmd,
	output logic             cmd_valid,
	input  logic             cmd_take
);
	cmd_t            q_mem [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic            push, pop, useful;

	assign in_ch.ready = (count_q != QPtrW'(0) + (QPtrW+1)'(QDepth));
	assign useful = in_ch.payload.has_byte | in_ch.payload.end_of_message;
	assign push = in_ch.valid & in_ch.ready & useful;
	assign cmd_valid = (count_q != '0);
	assign pop = cmd_valid & cmd_take;
	assign cmd = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{data_byte: in_ch.payload.data_byte,
				is_byte: in_ch.payload.has_byte, is_final: in_ch.payload.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
		end
	end
endmodule

// ===== src/shabs_back.sv =====
// back end: block packing, padding, round engine and digest output
module shabs_back import shabs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_take,
	shabs_out_if.source out_ch
);
	bk_state_t  state_q, state_d, ret_q;
	word_t      hash_q [8];
	word_t      blk_q [16];
	word_t      wv_q [8];
	word_t      wv_d [8];
	logic [5:0] fill_q;
	logic [63:0] bits_q, len_q;
	logic [5:0] rnd_q;
	logic [2:0] lcnt_q, ecnt_q;
	logic       push_en;
	logic [7:0] push_val;
	word_t      w15, w2, s0, s1, wnew, t1, t2, e, a;
	logic       out_busy_q;
	logic       out_load;
	logic       pad_first_q;

	// a digest word moves into the output register when it is free or being taken
	assign out_load = (state_q == ST_EMIT) && (!out_busy_q || out_ch.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) begin
				if (cmd.is_byte && fill_q == 6'd63) state_d = ST_COMP;
				else if (cmd.is_final) state_d = ST_PAD;
			end
			ST_PAD: if (fill_q == 6'd63) state_d = ST_COMP;
				else if (fill_q + 6'd1 == LenPos) state_d = ST_LEN;
			ST_LEN: if (lcnt_q == 3'd7) state_d = ST_COMP;
			ST_COMP: if (rnd_q == 6'd63) state_d = ret_q;
			ST_EMIT: if (out_load && ecnt_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// byte feed into the block
	always_comb begin
		push_en = 1'b0;
		push_val = 8'h00;
		cmd_take = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_take = cmd_valid;
				push_en = cmd_valid & cmd.is_byte;
				push_val = cmd.data_byte;
			end
			ST_PAD: begin
				push_en = 1'b1;
				push_val = pad_first_q ? PadByte : 8'h00;
			end
			ST_LEN: begin
				push_en = 1'b1;
				push_val = len_q[63 - 8*lcnt_q -: 8];
			end
			default: ;
		endcase
	end

	// schedule lives in blk_q, rotated each round; working vars in wv_q
	assign w15 = blk_q[1];
	assign w2 = blk_q[14];
	assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
	assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
	assign wnew = blk_q[0] + s0 + blk_q[9] + s1;
	assign e = wv_q[4];
	assign a = wv_q[0];
	assign t1 = wv_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & wv_q[5]) ^ (~e & wv_q[6])) + RoundK[rnd_q] + blk_q[0];
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

	// working vars after this round
	always_comb begin
		for (int j = 1; j < 8; j++) wv_d[j] = wv_q[j-1];
		wv_d[4] = wv_q[3] + t1;
		wv_d[0] = t1 + t2;
	end

	assign out_ch.valid = out_busy_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
			blk_q[15] <= wnew;
		end else if (push_en) begin
			if (fill_q[1:0] == 2'd0)
				blk_q[fill_q[5:2]] <= {push_val, 24'h0};
			else
				blk_q[fill_q[5:2]][(3 - fill_q[1:0])*8 +: 8] <= push_val;
		end
		if (state_q == ST_COMP) begin
			for (int j = 0; j < 8; j++) wv_q[j] <= wv_d[j];
		end else begin
			for (int j = 0; j < 8; j++) wv_q[j] <= hash_q[j];
		end
		if (state_q == ST_IDLE && cmd_valid && cmd.is_final)
			len_q <= bits_q + (cmd.is_byte ? 64'd8 : 64'd0);
		if (out_load)
			out_ch.payload <= '{digest_word: hash_q[ecnt_q], word_index: ecnt_q,
				last_word: ecnt_q == 3'd7};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			lcnt_q <= '0;
			ecnt_q <= '0;
			out_busy_q <= 1'b0;
			for (int j = 0; j < 8; j++) hash_q[j] <= InitHash[j];
		end else begin
			state_q <= state_d;
			if (push_en) fill_q <= fill_q + 6'd1;
			if (state_q == ST_IDLE && cmd_valid && cmd.is_byte) bits_q <= bits_q + 64'd8;
			// where to go once the block is compressed
			if (state_q != ST_COMP && state_d == ST_COMP) begin
				priority if (state_q == ST_LEN) ret_q <= ST_EMIT;
				else if (state_q == ST_PAD || cmd.is_final) ret_q <= ST_PAD;
				else ret_q <= ST_IDLE;
			end
			if (state_q == ST_LEN) lcnt_q <= lcnt_q + 3'd1;
			if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63)
					for (int j = 0; j < 8; j++) hash_q[j] <= hash_q[j] + wv_d[j];
			end
			if (out_load) begin
				out_busy_q <= 1'b1;
				ecnt_q <= ecnt_q + 3'd1;
				if (ecnt_q == 3'd7) begin
					for (int j = 0; j < 8; j++) hash_q[j] <= InitHash[j];
					fill_q <= '0;
					bits_q <= '0;
					lcnt_q <= '0;
				end
			end else if (out_ch.valid && out_ch.ready) begin
				out_busy_q <= 1'b0;
			end
		end
	end

	// padding opens with the marker byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_first_q <= 1'b0;
		else if (state_q == ST_IDLE && cmd_valid && cmd.is_final) pad_first_q <= 1'b1;
		else if (state_q == ST_PAD) pad_first_q <= 1'b0;
	end
endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// top level of the sha-256 byte-stream hasher
// in_ch carries one beat per byte (data_byte, has_byte, end_of_message);
// out_ch returns eight digest beats, word_index 0 first, last_word on the eighth.
// a front queue of four entries takes beats while the round engine works.
// the back end takes a byte from the queue while idle, and takes none while it
// compresses a block, which it does each time a block fills.
// end_of_message adds padding, the eight length bytes, one or two compressions,
// then eight output beats.
// a beat with neither byte nor end is dropped by the front.
// after reset the hash state holds the initial values and the queue is empty.
// when out_ch stalls the engine holds its output register and waits.
module sha256_byte_stream_hasher import shabs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	shabs_in_if.sink  in_ch,
	shabs_out_if.source out_ch
);
	cmd_t cmd;
	logic cmd_valid, cmd_take;

	shabs_front u_front (.clk, .arst_n, .in_ch, .cmd, .cmd_valid, .cmd_take);
	shabs_back  u_back (.clk, .arst_n, .cmd, .cmd_valid, .cmd_take, .out_ch);
endmodule

// ===== src/shabs_checker.sv =====
// port-level checks for the sha-256 hasher
`include "sha256_byte_stream_hasher_macros.svh"
module shabs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_index,
	input logic       out_last
);
	`SHA_ASSERT_IMP(a_last_at_seven, clk, arst_n, out_valid, out_last == (out_index == 3'd7))
	`SHA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_index))
	`SHA_ASSERT_NXT(a_order, clk, arst_n, out_valid && out_ready && !out_last,
		!out_valid || out_index == $past(out_index) + 3'd1)
endmodule

bind sha256_byte_stream_hasher shabs_checker u_chk (.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_index(out_ch.payload.word_index), .out_last(out_ch.payload.last_word));
